[src/saliency_heatmap_colorizer_assert.svh]
// Assertion macros shared by the colorizer checkers
`ifndef SALIENCY_HEATMAP_COLORIZER_ASSERT_SVH
`define SALIENCY_HEATMAP_COLORIZER_ASSERT_SVH

// Overlapping implication, disabled during reset
`define SHC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
	else $error("shc_checker: property failed");

// Next-cycle implication, disabled during reset
`define SHC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
	else $error("shc_checker: property failed");

// Next-cycle implication, live through reset
`define SHC_ASSERT_RST(lbl, clk_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
	else $error("shc_checker: reset property failed");

`endif

[src/shc_pkg.sv]
// Shared types and constants of the saliency heatmap colorizer
package shc_pkg;

	localparam int IDX_W   = 16;
	localparam int CH_W    = 5;
	localparam int PIX_W   = 17;
	localparam int POS_W   = 17;
	localparam int SUM_W   = 34;
	localparam int DIVN_W  = 50;
	localparam int DIVD_W  = 34;
	localparam int V_W     = 17;
	localparam int ONE_Q16 = 65536;

	typedef enum logic {
		CMD_LOAD,
		CMD_EMIT
	} cmd_kind_t;

	typedef enum logic [1:0] {
		CMAP_JET,
		CMAP_VIRIDIS,
		CMAP_HOT,
		CMAP_COOL
	} cmap_t;

	typedef enum logic [1:0] {
		REG_COLORMAP,
		REG_CHANNELS,
		REG_HEIGHT,
		REG_WIDTH
	} reg_idx_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_READ,
		BK_CALC,
		BK_DIVA_GO,
		BK_DIVA_WAIT,
		BK_AVG,
		BK_DIVM_GO,
		BK_DIVM_WAIT,
		BK_COLOR_GO,
		BK_COLOR_WAIT,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [IDX_W-1:0]    idx;
		logic signed [31:0]  sample;
		logic                first;
		logic                clear_max;
		logic                last_ch;
		logic [CH_W-1:0]     chans;
		cmap_t               cmap;
		logic                last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[src/shc_fifo.sv]
// Command queue between the front and back parts
module shc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  shc_pkg::cmd_t       din,
	input  logic                pop,
	output shc_pkg::cmd_t       dout,
	output shc_pkg::fifo_stat_t stat
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	shc_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	assign dout       = mem_q[rd_q];
	assign stat.full  = (cnt_q == (PW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

[src/shc_front.sv]
// Front part: accepts items, tracks frame positions, issues commands
module shc_front #(
	parameter int MAX_PIXELS   = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic signed [31:0]   sample,
	input  logic [1:0]           cmap_cfg,
	input  logic [2:0]           chan_cfg,
	input  logic [6:0]           height_cfg,
	input  logic [6:0]           width_cfg,
	input  shc_pkg::fifo_stat_t  fstat,
	output logic                 push,
	output shc_pkg::cmd_t        cmd
);

	localparam int AW = $clog2(MAX_PIXELS);
	localparam int TW = shc_pkg::CH_W + shc_pkg::PIX_W;

	logic [shc_pkg::POS_W-1:0] pos_q;
	logic [AW-1:0]             emit_q;
	logic                      loaded_q;

	logic [shc_pkg::CH_W-1:0]  chans;
	logic [6:0]                hc;
	logic [6:0]                wc;
	logic [13:0]               hw;
	logic [shc_pkg::PIX_W-1:0] npix;
	logic [TW-1:0]             total;
	logic [shc_pkg::POS_W-1:0] pos;
	logic [shc_pkg::POS_W-1:0] pos_next;
	logic [shc_pkg::CH_W-1:0]  quo;
	logic [TW-1:0]             base;
	logic [TW-1:0]             pix;
	logic                      load_done;
	logic [shc_pkg::PIX_W-1:0] e_ext;
	logic                      e_ok;
	logic                      e_last;
	logic                      accept;
	logic                      is_emit;

	function automatic logic [6:0] clamp_dim(input logic [6:0] d);
		if (d < 7'd2) return 7'd2;
		if (d > 7'd64) return 7'd64;
		return d;
	endfunction

	always_comb begin
		if (chan_cfg == 3'd0) chans = shc_pkg::CH_W'(1);
		else if ({2'b0, chan_cfg} > shc_pkg::CH_W'(MAX_CHANNELS))
			chans = shc_pkg::CH_W'(MAX_CHANNELS);
		else chans = {2'b0, chan_cfg};
	end

	assign hc = clamp_dim(height_cfg);
	assign wc = clamp_dim(width_cfg);
	assign hw = hc * wc;
	assign npix = ({3'b0, hw} > shc_pkg::PIX_W'(MAX_PIXELS)) ?
		shc_pkg::PIX_W'(MAX_PIXELS) : {3'b0, hw};
	assign total = TW'(chans) * TW'(npix);

	always_comb begin
		logic [shc_pkg::POS_W-1:0] ps;
		logic [TW-1:0]             km;
		ps = loaded_q ? '0 : pos_q;
		pos = (TW'(ps) >= total) ? '0 : ps;
		quo = '0;
		base = '0;
		for (int k = 1; k < MAX_CHANNELS; k++) begin
			km = TW'(k) * TW'(npix);
			if (TW'(pos) >= km) begin
				quo = shc_pkg::CH_W'(k);
				base = km;
			end
		end
		pix = TW'(pos) - base;
	end

	assign pos_next  = pos + shc_pkg::POS_W'(1);
	assign load_done = TW'(pos_next) >= total;
	assign e_ext     = shc_pkg::PIX_W'(emit_q);
	assign e_ok      = e_ext < npix;
	assign e_last    = e_ext == npix - shc_pkg::PIX_W'(1);

	assign in_ready = !fstat.full;
	assign accept   = in_valid && in_ready;
	assign is_emit  = shc_pkg::cmd_kind_t'(action) == shc_pkg::CMD_EMIT;
	assign push     = accept && (!is_emit || (loaded_q && e_ok));

	always_comb begin
		cmd.kind      = is_emit ? shc_pkg::CMD_EMIT : shc_pkg::CMD_LOAD;
		cmd.idx       = is_emit ? shc_pkg::IDX_W'(emit_q) : shc_pkg::IDX_W'(pix);
		cmd.sample    = sample;
		cmd.first     = (quo == '0);
		cmd.clear_max = (pos == '0);
		cmd.last_ch   = (quo == chans - shc_pkg::CH_W'(1));
		cmd.chans     = chans;
		cmd.cmap      = shc_pkg::cmap_t'(cmap_cfg);
		cmd.last      = e_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			emit_q   <= '0;
			loaded_q <= 1'b0;
		end else if (accept) begin
			if (!is_emit) begin
				if (load_done) begin
					loaded_q <= 1'b1;
					emit_q   <= '0;
					pos_q    <= '0;
				end else begin
					loaded_q <= 1'b0;
					pos_q    <= pos_next;
				end
			end else if (loaded_q) begin
				if (!e_ok || e_last) begin
					loaded_q <= 1'b0;
					emit_q   <= '0;
				end else begin
					emit_q <= emit_q + AW'(1);
				end
			end
		end
	end

endmodule

[src/shc_div.sv]
// Restoring divider, one quotient bit per cycle
module shc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [shc_pkg::DIVN_W-1:0]  dividend,
	input  logic [shc_pkg::DIVD_W-1:0]  divisor,
	output logic                        done,
	output logic [shc_pkg::DIVN_W-1:0]  quotient
);

	localparam int NW = shc_pkg::DIVN_W;
	localparam int DW = shc_pkg::DIVD_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/shc_color.sv]
// Colormap pipeline: Jet, Viridis, Hot and Cool to 8-bit RGB
module shc_color (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [shc_pkg::V_W-1:0]  v,
	input  shc_pkg::cmap_t           cmap,
	output logic                     out_valid,
	output logic [23:0]              rgb
);

	localparam logic [18:0] RECIP = 19'd268436;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic [shc_pkg::V_W-1:0] v_s1;
	logic [33:0]             vsq_s1;
	shc_pkg::cmap_t          cmap_s1, cmap_s2, cmap_s3;
	logic [23:0]             pw;
	logic [23:0]             pw_s1, pw_s2, pw_s3;
	logic signed [47:0]      num_s2 [3];
	logic [17:0]             t_s3 [3];
	logic [23:0]             rgb_s4;

	function automatic logic [7:0] to_byte(input logic signed [19:0] x);
		logic [27:0] p;
		if (x <= 0) return 8'd0;
		p = (28'(x) << 8) - 28'(x);
		if (p[27:16] > 12'd255) return 8'd255;
		return p[23:16];
	endfunction

	function automatic logic signed [47:0] poly(
		input logic signed [11:0] c0,
		input logic signed [11:0] c1,
		input logic signed [11:0] c2,
		input logic [shc_pkg::V_W-1:0] vv,
		input logic [33:0] vsq
	);
		logic signed [47:0] a, b, c;
		a = 48'(c0) <<< 32;
		b = (48'(c1) * $signed({31'b0, vv})) <<< 16;
		c = 48'(c2) * $signed({14'b0, vsq});
		return a + b + c;
	endfunction

	always_comb begin
		logic signed [19:0] vs, t3, g;
		vs = $signed({3'b0, v});
		t3 = vs * 20'sd3;
		pw = '0;
		case (cmap)
			shc_pkg::CMAP_JET: begin
				if (vs < 20'sd16384) begin
					pw = {8'd255, to_byte(vs <<< 2), 8'd0};
				end else if (vs < 20'sd32768) begin
					pw = {to_byte(20'sd65536 - ((vs - 20'sd16384) <<< 2)), 8'd255, 8'd0};
				end else if (vs < 20'sd49152) begin
					pw = {8'd0, 8'd255, to_byte((vs - 20'sd32768) <<< 2)};
				end else begin
					pw = {8'd0, to_byte(20'sd65536 - ((vs - 20'sd49152) <<< 2)), 8'd255};
				end
			end
			shc_pkg::CMAP_HOT: begin
				g = t3 - 20'sd65536;
				pw = {to_byte(t3 - 20'sd131072),
					to_byte(g > 20'sd65536 ? 20'sd65536 : g),
					to_byte(t3 > 20'sd65536 ? 20'sd65536 : t3)};
			end
			shc_pkg::CMAP_COOL: begin
				pw = {8'd255, to_byte(20'sd65536 - vs), to_byte(vs)};
			end
			default: pw = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		v_s1    <= v;
		vsq_s1  <= 34'(v) * 34'(v);
		cmap_s1 <= cmap;
		pw_s1   <= pw;

		num_s2[0] <= poly(12'sd267, 12'sd329, 12'sd404, v_s1, vsq_s1);
		num_s2[1] <= poly(12'sd4, 12'sd873, -12'sd377, v_s1, vsq_s1);
		num_s2[2] <= poly(12'sd329, 12'sd424, -12'sd753, v_s1, vsq_s1);
		cmap_s2   <= cmap_s1;
		pw_s2     <= pw_s1;

		for (int i = 0; i < 3; i++) begin
			logic signed [55:0] p;
			p = (56'(num_s2[i]) <<< 8) - 56'(num_s2[i]);
			t_s3[i] <= (num_s2[i] <= 0) ? 18'd0 : p[49:32];
		end
		cmap_s3 <= cmap_s2;
		pw_s3   <= pw_s2;

		if (cmap_s3 == shc_pkg::CMAP_VIRIDIS) begin
			for (int i = 0; i < 3; i++) begin
				logic [36:0] m;
				m = 37'(t_s3[i]) * 37'(RECIP);
				rgb_s4[8*i +: 8] <= (m[36:28] > 9'd255) ? 8'd255 : m[35:28];
			end
		end else begin
			rgb_s4 <= pw_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign rgb       = rgb_s4;

endmodule

[src/shc_back.sv]
// Back part: sum memory, averaging, normalization, colormap and output register
module shc_back #(
	parameter int MAX_PIXELS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shc_pkg::fifo_stat_t  fstat,
	input  shc_pkg::cmd_t        head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [23:0]          out_rgb,
	output logic                 out_last
);

	localparam int AW = $clog2(MAX_PIXELS);
	localparam int SW = shc_pkg::SUM_W;
	localparam int NW = shc_pkg::DIVN_W;
	localparam int DW = shc_pkg::DIVD_W;
	localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

	shc_pkg::back_state_t state_q, state_d;
	shc_pkg::cmd_t        cmd_q;
	logic [SW-1:0]        mem [MAX_PIXELS];
	logic [SW-1:0]        rdata_q;
	logic [AW-1:0]        clr_q;
	logic                 clr_done_q;
	logic signed [SW-1:0] sum_q;
	logic signed [SW-1:0] avg_q;
	logic signed [SW-1:0] max_q;
	logic [shc_pkg::V_W-1:0] v_q;
	logic [23:0]          rgb_q;
	logic                 ov_q;
	logic [23:0]          orgb_q;
	logic                 olast_q;

	logic [AW-1:0]        addr;
	logic signed [SW-1:0] samp_ext;
	logic signed [SW-1:0] new_sum;
	logic [SW-1:0]        sum_abs;
	logic                 is_load;
	logic                 go_norm;
	logic                 slot_free;

	logic                 div_start;
	logic [NW-1:0]        div_n;
	logic [DW-1:0]        div_d;
	logic                 div_done;
	logic [NW-1:0]        div_q;
	logic                 col_start;
	logic                 col_valid;
	logic [23:0]          col_rgb;

	assign addr      = cmd_q.idx[AW-1:0];
	assign samp_ext  = {{(SW-32){cmd_q.sample[31]}}, cmd_q.sample};
	assign new_sum   = cmd_q.first ? samp_ext : $signed(rdata_q) + samp_ext;
	assign sum_abs   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign is_load   = cmd_q.kind == shc_pkg::CMD_LOAD;
	assign go_norm   = (max_q > 0) && (avg_q > 0);
	assign slot_free = !ov_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shc_pkg::BK_IDLE:       if (!fstat.empty && clr_done_q) state_d = shc_pkg::BK_READ;
			shc_pkg::BK_READ:       state_d = shc_pkg::BK_CALC;
			shc_pkg::BK_CALC:       state_d = (is_load && !cmd_q.last_ch) ?
				shc_pkg::BK_IDLE : shc_pkg::BK_DIVA_GO;
			shc_pkg::BK_DIVA_GO:    state_d = shc_pkg::BK_DIVA_WAIT;
			shc_pkg::BK_DIVA_WAIT:  if (div_done) state_d = shc_pkg::BK_AVG;
			shc_pkg::BK_AVG: begin
				if (is_load) state_d = shc_pkg::BK_IDLE;
				else if (go_norm) state_d = shc_pkg::BK_DIVM_GO;
				else state_d = shc_pkg::BK_COLOR_GO;
			end
			shc_pkg::BK_DIVM_GO:    state_d = shc_pkg::BK_DIVM_WAIT;
			shc_pkg::BK_DIVM_WAIT:  if (div_done) state_d = shc_pkg::BK_COLOR_GO;
			shc_pkg::BK_COLOR_GO:   state_d = shc_pkg::BK_COLOR_WAIT;
			shc_pkg::BK_COLOR_WAIT: if (col_valid) state_d = shc_pkg::BK_OUT;
			shc_pkg::BK_OUT:        if (slot_free) state_d = shc_pkg::BK_IDLE;
			default:                state_d = shc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == shc_pkg::BK_IDLE) && !fstat.empty && clr_done_q;
		div_start = (state_q == shc_pkg::BK_DIVA_GO) || (state_q == shc_pkg::BK_DIVM_GO);
		col_start = (state_q == shc_pkg::BK_COLOR_GO);
		if (state_q == shc_pkg::BK_DIVM_GO) begin
			div_n = {SW'(avg_q), 16'b0};
			div_d = DW'(max_q);
		end else begin
			div_n = NW'(sum_abs);
			div_d = DW'(cmd_q.chans);
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[addr];
		if (!clr_done_q) begin
			mem[clr_q] <= '0;
		end else if (state_q == shc_pkg::BK_CALC && is_load) begin
			mem[addr] <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if (state_q == shc_pkg::BK_CALC) begin
			sum_q <= is_load ? new_sum : $signed(rdata_q);
		end
		if (state_q == shc_pkg::BK_DIVA_WAIT && div_done) begin
			avg_q <= sum_q[SW-1] ? -$signed(div_q[SW-1:0]) : $signed(div_q[SW-1:0]);
		end
		if (state_q == shc_pkg::BK_AVG) v_q <= '0;
		if (state_q == shc_pkg::BK_DIVM_WAIT && div_done) begin
			v_q <= (div_q > NW'(shc_pkg::ONE_Q16)) ?
				shc_pkg::V_W'(shc_pkg::ONE_Q16) : div_q[shc_pkg::V_W-1:0];
		end
		if (state_q == shc_pkg::BK_COLOR_WAIT && col_valid) rgb_q <= col_rgb;
		if (state_q == shc_pkg::BK_OUT && slot_free) begin
			orgb_q  <= rgb_q;
			olast_q <= cmd_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= shc_pkg::BK_IDLE;
			clr_q      <= '0;
			clr_done_q <= 1'b0;
			max_q      <= MOST_NEG;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (!clr_done_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(MAX_PIXELS - 1)) clr_done_q <= 1'b1;
			end
			if (state_q == shc_pkg::BK_CALC && is_load && cmd_q.clear_max) max_q <= MOST_NEG;
			if (state_q == shc_pkg::BK_AVG && is_load && avg_q > max_q) max_q <= avg_q;
			if (state_q == shc_pkg::BK_OUT && slot_free) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	shc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	shc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (col_start),
		.v         (v_q),
		.cmap      (cmd_q.cmap),
		.out_valid (col_valid),
		.rgb       (col_rgb)
	);

	assign out_valid = ov_q;
	assign out_rgb   = orgb_q;
	assign out_last  = olast_q;

endmodule

[src/saliency_heatmap_colorizer.sv]
// Top level of the saliency heatmap colorizer
// Load item: the back part reads and updates the pixel sum, and runs the channel divide
// when it closes a pixel. Emit item: a 50-step pass of the shared divider for the average,
// a second pass for normalization when the maximum and average are positive, then the
// 4-stage colormap pipeline; a 4-entry command queue decouples input.
// Reset is asynchronous, active low; a pass over every address then zeroes the sum memory.
module saliency_heatmap_colorizer #(
	parameter int MAX_PIXELS   = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red, green, blue
	output logic        m_tlast,   // pixel_last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	logic [1:0] cmap_q;
	logic [2:0] chan_q;
	logic [6:0] height_q;
	logic [6:0] width_q;

	logic                push;
	logic                pop;
	shc_pkg::cmd_t       cmd_in;
	shc_pkg::cmd_t       cmd_out;
	shc_pkg::fifo_stat_t fstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmap_q   <= 2'd0;
			chan_q   <= 3'd1;
			height_q <= 7'd64;
			width_q  <= 7'd64;
		end else if (cfg_we) begin
			case (shc_pkg::reg_idx_t'(cfg_index))
				shc_pkg::REG_COLORMAP: cmap_q   <= cfg_data[1:0];
				shc_pkg::REG_CHANNELS: chan_q   <= cfg_data[2:0];
				shc_pkg::REG_HEIGHT:   height_q <= cfg_data;
				shc_pkg::REG_WIDTH:    width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	shc_front #(
		.MAX_PIXELS   (MAX_PIXELS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser),
		.sample     (s_tdata),
		.cmap_cfg   (cmap_q),
		.chan_cfg   (chan_q),
		.height_cfg (height_q),
		.width_cfg  (width_q),
		.fstat      (fstat),
		.push       (push),
		.cmd        (cmd_in)
	);

	shc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.pop    (pop),
		.dout   (cmd_out),
		.stat   (fstat)
	);

	shc_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fstat     (fstat),
		.head      (cmd_out),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rgb   (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

[src/shc_checker.sv]
// Port checker for the colorizer, bound to the top level
`include "saliency_heatmap_colorizer_assert.svh"

module shc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	`SHC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`SHC_ASSERT_RST(a_rst_no_out, clk, !arst_n, !m_tvalid)
	`SHC_ASSERT_RST(a_rst_ready, clk, !arst_n, s_tready)
	`SHC_ASSERT_NOW(a_out_after_rise, clk, arst_n, $rose(m_tvalid), !$past(m_tvalid))

endmodule

bind saliency_heatmap_colorizer shc_checker u_chk (.*);

[sim/saliency_heatmap_colorizer_tb.sv]
// Self-checking testbench of the saliency heatmap colorizer: frame loads, colored pixel emits
module saliency_heatmap_colorizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	typedef struct {
		shc_pkg::cmd_kind_t kind;
		logic [31:0]        sample;
		bit                 typed;
		pixel_t             px;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	saliency_heatmap_colorizer DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// colorizer state as seen from outside
	logic [1:0]  cm_sel;
	logic [2:0]  ch_reg;
	logic [6:0]  h_reg, w_reg;
	longint      pix_sum [4096];
	longint      max_avg;
	int          load_pos, emit_pos;
	bit          loaded;
	pixel_t      pending_pixels [$];
	int          errors = 0;
	int          burst_left = 0;
	int          items_sent = 0;

	function automatic int dim_of(logic [6:0] d);
		return d < 2 ? 2 : (d > 64 ? 64 : int'(d));
	endfunction

	function automatic int chans_of();
		return ch_reg < 1 ? 1 : (ch_reg > 4 ? 4 : int'(ch_reg));
	endfunction

	function automatic logic [7:0] q16_to_byte(longint x);
		longint r;
		if (x <= 0)
			return 8'd0;
		r = (x * 255) >>> 16;
		return r > 255 ? 8'd255 : r[7:0];
	endfunction

	function automatic logic [7:0] viridis_byte(longint c0, longint c1, longint c2, longint v);
		longint num, r;
		num = c0 * (longint'(1) << 32) + c1 * v * 65536 + c2 * v * v;
		if (num <= 0)
			return 8'd0;
		r = (num * 255) / (1000 * (longint'(1) << 32));
		return r > 255 ? 8'd255 : r[7:0];
	endfunction

	function automatic pixel_t color_of(longint v);
		pixel_t p;
		longint g;
		p.last = 0;
		case (shc_pkg::cmap_t'(cm_sel))
			shc_pkg::CMAP_JET: begin
				if (v < 16384) begin
					p.red = 0; p.green = q16_to_byte(4 * v); p.blue = 255;
				end else if (v < 32768) begin
					p.red = 0; p.green = 255; p.blue = q16_to_byte(65536 - 4 * (v - 16384));
				end else if (v < 49152) begin
					p.red = q16_to_byte(4 * (v - 32768)); p.green = 255; p.blue = 0;
				end else begin
					p.red = 255; p.green = q16_to_byte(65536 - 4 * (v - 49152)); p.blue = 0;
				end
			end
			shc_pkg::CMAP_VIRIDIS: begin
				p.red = viridis_byte(267, 329, 404, v);
				p.green = viridis_byte(4, 873, -377, v);
				p.blue = viridis_byte(329, 424, -753, v);
			end
			shc_pkg::CMAP_HOT: begin
				p.red = q16_to_byte(3 * v > 65536 ? 65536 : 3 * v);
				g = 3 * v - 65536;
				p.green = q16_to_byte(g > 65536 ? 65536 : g);
				p.blue = q16_to_byte(3 * v - 2 * 65536);
			end
			default: begin
				p.red = q16_to_byte(v);
				p.green = q16_to_byte(65536 - v);
				p.blue = 255;
			end
		endcase
		return p;
	endfunction

	function automatic bit colorize_step(shc_pkg::cmd_kind_t kind, logic signed [31:0] smp,
			output pixel_t px);
		int chans, npix, total, pos, pix;
		longint avg, v, q;
		chans = chans_of();
		npix = dim_of(h_reg) * dim_of(w_reg);
		if (kind == shc_pkg::CMD_LOAD) begin
			total = chans * npix;
			if (loaded) begin
				loaded = 0;
				load_pos = 0;
			end
			pos = load_pos >= total ? 0 : load_pos;
			pix = pos % npix;
			if (pos < npix) begin
				if (pos == 0)
					max_avg = -(longint'(1) << 33);
				pix_sum[pix] = longint'(smp);
			end else
				pix_sum[pix] += longint'(smp);
			if (pos / npix == chans - 1) begin
				avg = pix_sum[pix] / chans;
				if (avg > max_avg)
					max_avg = avg;
			end
			pos++;
			if (pos >= total) begin
				loaded = 1;
				emit_pos = 0;
				load_pos = 0;
			end else
				load_pos = pos;
			return 0;
		end
		if (!loaded)
			return 0;
		if (emit_pos >= npix) begin
			loaded = 0;
			emit_pos = 0;
			return 0;
		end
		avg = pix_sum[emit_pos] / chans;
		v = 0;
		if (max_avg > 0 && avg > 0) begin
			q = (avg <<< 16) / max_avg;
			v = q > 65536 ? 65536 : q;
		end
		px = color_of(v);
		px.last = emit_pos == npix - 1;
		if (px.last) begin
			loaded = 0;
			emit_pos = 0;
		end else
			emit_pos = emit_pos + 1;
		return 1;
	endfunction

	task automatic send_item(shc_pkg::cmd_kind_t kind, logic [31:0] smp, bit typed,
			pixel_t typed_px);
		pixel_t px;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (colorize_step(kind, smp, px))
			pending_pixels.push_back(typed ? typed_px : px);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		burst_left = 0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(shc_pkg::reg_idx_t idx, logic [6:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			shc_pkg::REG_COLORMAP: cm_sel = val[1:0];
			shc_pkg::REG_CHANNELS: ch_reg = val[2:0];
			shc_pkg::REG_HEIGHT:   h_reg = val;
			shc_pkg::REG_WIDTH:    w_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_geometry(logic [1:0] cm, logic [2:0] ch, logic [6:0] h, logic [6:0] w);
		write_reg(shc_pkg::REG_COLORMAP, {5'd0, cm});
		write_reg(shc_pkg::REG_CHANNELS, {4'd0, ch});
		write_reg(shc_pkg::REG_HEIGHT, h);
		write_reg(shc_pkg::REG_WIDTH, w);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0003_ffff);
			2: return -$urandom_range(0, 32'h0003_ffff);
			default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
		endcase
	endfunction

	// receiver: switches among random stall modes and checks each pixel taken
	int rx_cycle = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		pixel_t want;
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= $urandom_range(0, 3) == 0;
			default: m_tready <= (rx_cycle % 8) < 5;
		endcase
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[7:0] !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("pixel_last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	row_t directed [$];
	pixel_t no_px = '{0, 0, 0, 0};

	initial begin
		int npix, total, n, sel;
		cm_sel = 0; ch_reg = 1; h_reg = 64; w_reg = 64;
		foreach (pix_sum[i])
			pix_sum[i] = 0;
		max_avg = -(longint'(1) << 33);
		load_pos = 0; emit_pos = 0; loaded = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		set_geometry(shc_pkg::CMAP_JET, 3'd1, 7'd2, 7'd2);
		directed = '{
			'{shc_pkg::CMD_EMIT, 32'h0,          1, no_px},
			'{shc_pkg::CMD_LOAD, 32'h7fff_ffff,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h8000_0000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h0000_0000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h4000_0000,  0, no_px},
			'{shc_pkg::CMD_EMIT, 32'hffff_ffff,  1, '{255, 0, 0, 0}},
			'{shc_pkg::CMD_EMIT, 32'h0,          1, '{0, 0, 255, 0}},
			'{shc_pkg::CMD_EMIT, 32'h0,          1, '{0, 0, 255, 0}},
			'{shc_pkg::CMD_EMIT, 32'h0,          0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          1, no_px},
			'{shc_pkg::CMD_LOAD, 32'hffff_0000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h8000_0000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h0000_0001,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'hffff_ffff,  0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          1, '{0, 0, 255, 0}},
			'{shc_pkg::CMD_EMIT, 32'h0,          1, '{0, 0, 255, 0}},
			'{shc_pkg::CMD_LOAD, 32'h0001_0000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h0000_8000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h0000_4000,  0, no_px},
			'{shc_pkg::CMD_LOAD, 32'h0000_0000,  0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          0, no_px},
			'{shc_pkg::CMD_EMIT, 32'h0,          0, no_px}
		};
		foreach (directed[i]) begin
			pixel_t px;
			px = directed[i].px;
			if (directed[i].kind == shc_pkg::CMD_EMIT && i != 0 && i != 9 && directed[i].typed)
				px.last = 0;
			send_item(directed[i].kind, directed[i].sample,
				directed[i].typed && px.red + px.green + px.blue != 0, px);
		end
		drain();

		for (int ph = 0; items_sent < 700; ph++) begin
			case (ph % 8)
				0: set_geometry(2'(ph / 8), 3'd4, 7'd8, 7'd2);
				1: set_geometry(2'(3 - ph / 8 % 4), 3'd1, 7'd2, 7'd100);
				2: set_geometry(2'($urandom), 3'($urandom),
					7'($urandom_range(0, 3)), 7'($urandom_range(0, 3)));
				default: set_geometry(2'($urandom), 3'($urandom_range(1, 4)),
					7'($urandom_range(2, 5)), 7'($urandom_range(2, 5)));
			endcase
			npix = dim_of(h_reg) * dim_of(w_reg);
			total = chans_of() * npix;
			repeat (ph % 8 < 2 ? 1 : $urandom_range(1, 3)) begin
				sel = $urandom_range(0, 9);
				if (sel < 7 || total > 200) begin
					for (int k = 0; k < total; k++)
						send_item(shc_pkg::CMD_LOAD, rand_sample(), 0, no_px);
					n = sel == 5 ? $urandom_range(0, npix - 1) : npix + (sel == 6 ? 2 : 0);
					for (int k = 0; k < n; k++)
						send_item(shc_pkg::CMD_EMIT, rand_sample(), 0, no_px);
				end else begin
					repeat ($urandom_range(1, 12))
						send_item(shc_pkg::cmd_kind_t'($urandom_range(0, 1)), rand_sample(),
							0, no_px);
				end
			end
			drain();
		end

		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/shc_pkg.sv
src/shc_fifo.sv
src/shc_front.sv
src/shc_div.sv
src/shc_color.sv
src/shc_back.sv
src/saliency_heatmap_colorizer.sv
src/shc_checker.sv
sim/saliency_heatmap_colorizer_tb.sv
